// ===== rtl/pixel_format_pack_assert.svh =====
// ----------------------------------------------------------------------------
// pixel_format_pack assertion macros
// shared concurrent assertion forms used by the port checker
// ----------------------------------------------------------------------------
`ifndef PIXEL_FORMAT_PACK_ASSERT_SVH
`define PIXEL_FORMAT_PACK_ASSERT_SVH

// same-cycle implication, disabled in reset
`define PFP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define PFP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pfp_pkg.sv =====
// ----------------------------------------------------------------------------
// pfp_pkg
// shared constants, codes, types and format helpers of the pixel packer
// ----------------------------------------------------------------------------
package pfp_pkg;

  // palette storage
  localparam int PAL_DEPTH = 256;
  localparam int PAL_AW    = (PAL_DEPTH > 1) ? $clog2(PAL_DEPTH) : 1;
  localparam int PAL_CW    = PAL_AW + 1;

  // field widths
  localparam int CH_W   = 8;
  localparam int PX_W   = 4 * CH_W;
  localparam int WORD_W = 32;
  localparam int FMT_W  = 3;
  localparam int BPP_W  = 6;
  localparam int DIST_W = 2 * CH_W + 2;

  // opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  // pixel format codes
  localparam logic [FMT_W-1:0] FMT_RGBA8888 = 3'd0;
  localparam logic [FMT_W-1:0] FMT_RGBA5551 = 3'd1;
  localparam logic [FMT_W-1:0] FMT_PAL8     = 3'd2;
  localparam logic [FMT_W-1:0] FMT_PAL4     = 3'd3;
  localparam logic [FMT_W-1:0] FMT_PAL2     = 3'd4;
  localparam logic [FMT_W-1:0] FMT_PAL1     = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_PACK
  } pfp_state_t;

  // search request and response
  typedef struct packed {
    logic              start;
    logic [PX_W-1:0]   pixel;
    logic [PAL_CW-1:0] count;
  } srch_req_t;

  typedef struct packed {
    logic              done;
    logic [PAL_AW-1:0] near_idx;
  } srch_rsp_t;

  // pack request
  typedef struct packed {
    logic              en;
    logic [WORD_W-1:0] value;
    logic [BPP_W-1:0]  bpp;
    logic              row_end;
  } pack_req_t;

  function automatic logic fmt_is_pal(input logic [FMT_W-1:0] f);
    return f inside {[FMT_PAL8:FMT_PAL1]};
  endfunction

  function automatic logic [BPP_W-1:0] fmt_bpp(input logic [FMT_W-1:0] f);
    logic [BPP_W-1:0] b;
    case (f)
      FMT_RGBA5551: b = 6'd16;
      FMT_PAL8:     b = 6'd8;
      FMT_PAL4:     b = 6'd4;
      FMT_PAL2:     b = 6'd2;
      FMT_PAL1:     b = 6'd1;
      default:      b = 6'd32;
    endcase
    return b;
  endfunction

  // entries searched, capped at the palette depth
  function automatic logic [PAL_CW-1:0] fmt_entries(input logic [FMT_W-1:0] f);
    int n;
    case (f)
      FMT_PAL8: n = 256;
      FMT_PAL4: n = 16;
      FMT_PAL2: n = 4;
      default:  n = 2;
    endcase
    if (n > PAL_DEPTH) n = PAL_DEPTH;
    return PAL_CW'(n);
  endfunction

endpackage

// ===== rtl/pfp_if.sv =====
// ----------------------------------------------------------------------------
// pfp_if
// valid/ready channels of the pixel packer: pixel beats in, word beats out
// ----------------------------------------------------------------------------
interface pfp_in_if import pfp_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            opcode;
  logic [CH_W-1:0] palette_index;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;
  logic [CH_W-1:0] alpha;
  logic            row_end;

  modport source (output valid, opcode, palette_index, red, green, blue, alpha,
                  row_end, input ready);
  modport sink   (input valid, opcode, palette_index, red, green, blue, alpha,
                  row_end, output ready);
endinterface

interface pfp_out_if import pfp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] packed_word;
  logic              row_last;

  modport source (output valid, packed_word, row_last, input ready);
  modport sink   (input valid, packed_word, row_last, output ready);
endinterface

// ===== rtl/pfp_ram.sv =====
// ----------------------------------------------------------------------------
// pfp_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module pfp_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered; data is valid in the cycle after the read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/pfp_search.sv =====
// ----------------------------------------------------------------------------
// pfp_search
// nearest palette entry search, one entry read from the palette ram per cycle
// ----------------------------------------------------------------------------
module pfp_search import pfp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  srch_req_t         req,
  output srch_rsp_t         rsp,
  output logic              rd_en,
  output logic [PAL_AW-1:0] rd_addr,
  input  logic [PX_W-1:0]   rd_data
);

  logic              busy_r, busy_nxt;
  logic [PX_W-1:0]   px_r;
  logic [PAL_CW-1:0] cnt_r;
  logic [PAL_CW-1:0] iss_r, iss_nxt;
  logic              rd_vld_r;
  logic [PAL_AW-1:0] rd_idx_r;
  logic              dist_vld_r;
  logic [PAL_AW-1:0] dist_idx_r;
  logic [DIST_W-1:0] dist_r;
  logic [DIST_W-1:0] best_d_r, best_d_nxt;
  logic [PAL_AW-1:0] best_r, best_nxt;
  logic              issue;
  logic              done;

  // squared difference of one channel
  function automatic logic [2*CH_W-1:0] chan_sq(input logic [CH_W-1:0] a,
                                                input logic [CH_W-1:0] b);
    logic [CH_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return (2*CH_W)'(d) * (2*CH_W)'(d);
  endfunction

  // summed squared distance over the four channels
  function automatic logic [DIST_W-1:0] color_dist(input logic [PX_W-1:0] p,
                                                   input logic [PX_W-1:0] e);
    logic [DIST_W-1:0] s;
    s = '0;
    for (int c = 0; c < 4; c++) begin
      s = s + DIST_W'(chan_sq(p[c*CH_W +: CH_W], e[c*CH_W +: CH_W]));
    end
    return s;
  endfunction

  // issue reads until the count is reached or an exact match is seen
  assign issue   = busy_r && (iss_r < cnt_r) && (best_d_r != '0);
  assign rd_en   = issue;
  assign rd_addr = iss_r[PAL_AW-1:0];
  assign done    = busy_r && !issue && !rd_vld_r && !dist_vld_r;

  assign rsp.done     = done;
  assign rsp.near_idx = best_r;

  // sequencer control
  always_comb begin
    busy_nxt = busy_r;
    iss_nxt  = iss_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      iss_nxt  = '0;
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (issue) begin
      iss_nxt = iss_r + PAL_CW'(1);
    end
  end

  // best-so-far update, strict compare keeps the lowest index on ties
  always_comb begin
    best_d_nxt = best_d_r;
    best_nxt   = best_r;
    if (req.start) begin
      best_d_nxt = '1;
      best_nxt   = '0;
    end else if (dist_vld_r && (dist_r < best_d_r)) begin
      best_d_nxt = dist_r;
      best_nxt   = dist_idx_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      rd_vld_r   <= 1'b0;
      dist_vld_r <= 1'b0;
    end else begin
      busy_r     <= busy_nxt;
      rd_vld_r   <= issue;
      dist_vld_r <= rd_vld_r;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (req.start) begin
      px_r  <= req.pixel;
      cnt_r <= req.count;
    end
    iss_r      <= iss_nxt;
    rd_idx_r   <= rd_addr;
    dist_idx_r <= rd_idx_r;
    dist_r     <= color_dist(px_r, rd_data);
    best_d_r   <= best_d_nxt;
    best_r     <= best_nxt;
  end

endmodule

// ===== rtl/pfp_packer.sv =====
// ----------------------------------------------------------------------------
// pfp_packer
// merges converted pixels lsb-first into a word and holds the output beat
// ----------------------------------------------------------------------------
module pfp_packer import pfp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  pack_req_t  req,
  output logic       can_pack,
  pfp_out_if.source  out_ch
);

  logic [WORD_W-1:0] pend_r, pend_nxt;
  logic [BPP_W-1:0]  fill_r, fill_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic [WORD_W-1:0] out_word_r;
  logic              out_last_r;
  logic [WORD_W-1:0] merged;
  logic [BPP_W-1:0]  fill_sum;
  logic              emit;

  // new pixel at the current fill position, bits past the top dropped
  assign merged   = pend_r | (req.value << fill_r[4:0]);
  assign fill_sum = fill_r + req.bpp;
  assign emit     = (fill_sum >= BPP_W'(WORD_W)) || req.row_end;
  assign can_pack = !out_vld_r || out_ch.ready;

  // pending word and fill
  always_comb begin
    pend_nxt    = pend_r;
    fill_nxt    = fill_r;
    out_vld_nxt = out_vld_r && !out_ch.ready;
    if (req.en) begin
      if (emit) begin
        pend_nxt    = '0;
        fill_nxt    = '0;
        out_vld_nxt = 1'b1;
      end else begin
        pend_nxt = merged;
        fill_nxt = fill_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r    <= '0;
      fill_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      pend_r    <= pend_nxt;
      fill_r    <= fill_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // output beat payload
  always_ff @(posedge clk) begin
    if (req.en && emit) begin
      out_word_r <= merged;
      out_last_r <= req.row_end;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.packed_word = out_word_r;
  assign out_ch.row_last    = out_last_r;

endmodule

// ===== rtl/pixel_format_pack.sv =====
// ----------------------------------------------------------------------------
// pixel_format_pack
// rgba8888 pixel converter and 32-bit word packer with palette lookup
// ----------------------------------------------------------------------------
// One beat is taken at a time. A palette load leaves the block ready. An
// rgba8888 or rgba5551 pixel goes straight to its pack step. A palette pixel
// first searches N entries (256, 16, 4 or 2 for pal8/pal4/pal2/pal1, or fewer
// when an exact match ends the search early); the palette ram has a single
// read port, which yields one entry per cycle. Words are held in an output
// register, so the next pixel is taken while a word waits; that pixel then
// stalls in its pack step, whether or not it completes a word, until the held
// word is taken. Palette entries read before being loaded return undefined
// indices. The pixel format register must be written only while no pixel is
// in flight; a format change keeps the partly filled word.
module pixel_format_pack import pfp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [FMT_W-1:0] cfg_wdata,
  pfp_in_if.sink           in_ch,
  pfp_out_if.source        out_ch
);

  pfp_state_t        state_r, state_nxt;
  logic [FMT_W-1:0]  fmt_r;
  logic [PX_W-1:0]   px;
  logic [WORD_W-1:0] value_r;
  logic              row_end_r;
  logic              in_fire;
  logic              pix_fire;
  logic              pal_fmt;
  logic              can_pack;
  logic              srch_start;
  logic              pack_en;
  logic [WORD_W-1:0] direct_value;
  srch_req_t         srch_req;
  srch_rsp_t         srch_rsp;
  pack_req_t         pack_req;
  logic              ram_we;
  logic              ram_re;
  logic [PAL_AW-1:0] ram_raddr;
  logic [PX_W-1:0]   ram_rdata;

  assign px       = {in_ch.alpha, in_ch.blue, in_ch.green, in_ch.red};
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign pix_fire = in_fire && (in_ch.opcode == OP_PIXEL);
  assign pal_fmt  = fmt_is_pal(fmt_r);

  // format register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_RGBA8888;
    end else if (cfg_we) begin
      fmt_r <= cfg_wdata;
    end
  end

  // direct conversions
  always_comb begin
    case (fmt_r)
      FMT_RGBA5551: direct_value = {16'd0, in_ch.alpha[7], in_ch.blue[7:3],
                                    in_ch.green[7:3], in_ch.red[7:3]};
      default:      direct_value = px;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (pix_fire) state_nxt = pal_fmt ? ST_SEARCH : ST_PACK;
      end
      ST_SEARCH: begin
        if (srch_rsp.done) state_nxt = ST_PACK;
      end
      ST_PACK: begin
        if (can_pack) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control outputs
  always_comb begin
    in_ch.ready = 1'b0;
    srch_start  = 1'b0;
    pack_en     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        srch_start  = pix_fire && pal_fmt;
      end
      ST_PACK: begin
        pack_en = can_pack;
      end
      default: ;
    endcase
  end

  // pixel value and row flag
  always_ff @(posedge clk) begin
    if (pix_fire) begin
      value_r   <= direct_value;
      row_end_r <= in_ch.row_end;
    end else if (state_r == ST_SEARCH && srch_rsp.done) begin
      value_r <= WORD_W'(srch_rsp.near_idx);
    end
  end

  assign srch_req.start = srch_start;
  assign srch_req.pixel = px;
  assign srch_req.count = fmt_entries(fmt_r);

  assign pack_req.en      = pack_en;
  assign pack_req.value   = value_r;
  assign pack_req.bpp     = fmt_bpp(fmt_r);
  assign pack_req.row_end = row_end_r;

  // palette loads beyond the depth are dropped
  assign ram_we = in_fire && (in_ch.opcode == OP_LOAD) &&
                  ({1'b0, in_ch.palette_index} < 9'(PAL_DEPTH));

  pfp_ram #(
    .DEPTH (PAL_DEPTH),
    .WIDTH (PX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (in_ch.palette_index[PAL_AW-1:0]),
    .wr_data (px),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  pfp_search u_search (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (srch_req),
    .rsp     (srch_rsp),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  pfp_packer u_packer (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (pack_req),
    .can_pack (can_pack),
    .out_ch   (out_ch)
  );

endmodule

// ===== rtl/pfp_check.sv =====
// ----------------------------------------------------------------------------
// pfp_check
// port-level checks of the pixel packer, bound to the top level
// ----------------------------------------------------------------------------
`include "pixel_format_pack_assert.svh"

module pfp_check import pfp_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_opcode,
  input logic              out_valid,
  input logic              out_ready,
  input logic [WORD_W-1:0] out_packed_word,
  input logic              out_row_last
);

  // a word beat waits until taken
  `PFP_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "out beat dropped")

  // a waiting word keeps its payload
  `PFP_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_packed_word) && $stable(out_row_last), "out payload changed")

  // an accepted pixel beat makes the block drop ready
  `PFP_ASSERT_NXT(a_pix_busy, clk, rst_n, in_valid && in_ready && (in_opcode == OP_PIXEL), !in_ready, "ready after pixel")

  // a palette load leaves the block ready
  `PFP_ASSERT_NXT(a_load_ready, clk, rst_n, in_valid && in_ready && (in_opcode == OP_LOAD), in_ready, "not ready after load")

endmodule

bind pixel_format_pack pfp_check u_pfp_check (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_opcode       (in_ch.opcode),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_packed_word (out_ch.packed_word),
  .out_row_last    (out_ch.row_last)
);

// ===== verif/pfp_word_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pfp_word_checker
// watches the pixel and word channels of the packer, predicts every packed
// word from the accepted pixel beats and compares it field by field with the
// word the block delivers
// ----------------------------------------------------------------------------
module pfp_word_checker import pfp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [FMT_W-1:0] cfg_wdata,
  pfp_in_if                in_ch,
  pfp_out_if               out_ch,
  output int               fail_count,
  output int               words_pending,
  output int               words_checked
);

  typedef struct {
    logic [WORD_W-1:0] packed_word;
    logic              row_last;
  } word_beat_t;

  logic [PX_W-1:0]   palette_copy [PAL_DEPTH];
  logic [WORD_W-1:0] fill_word;
  int unsigned       fill_count;
  logic [FMT_W-1:0]  cur_format;
  word_beat_t        expected_words [$];
  int                mismatches = 0;
  int                checked = 0;

  // bits one pixel takes in the word
  function automatic int unsigned pixel_bits(input logic [FMT_W-1:0] f);
    case (f)
      FMT_RGBA5551: return 16;
      FMT_PAL8:     return 8;
      FMT_PAL4:     return 4;
      FMT_PAL2:     return 2;
      FMT_PAL1:     return 1;
      default:      return 32;
    endcase
  endfunction

  // palette entries a search looks at
  function automatic int unsigned search_span(input logic [FMT_W-1:0] f);
    int unsigned n;
    case (f)
      FMT_PAL8: n = 256;
      FMT_PAL4: n = 16;
      FMT_PAL2: n = 4;
      default:  n = 2;
    endcase
    if (n > PAL_DEPTH) n = PAL_DEPTH;
    return n;
  endfunction

  // summed squared channel difference
  function automatic int unsigned color_distance(input logic [PX_W-1:0] px,
                                                 input logic [PX_W-1:0] entry);
    int unsigned sum;
    int          d;
    sum = 0;
    for (int s = 0; s < 4; s++) begin
      d = int'(px[s*CH_W +: CH_W]) - int'(entry[s*CH_W +: CH_W]);
      sum += d * d;
    end
    return sum;
  endfunction

  // lowest index wins ties, an exact hit ends the search
  function automatic logic [WORD_W-1:0] closest_entry(input logic [PX_W-1:0] px,
                                                      input int unsigned span);
    int unsigned best;
    int unsigned best_d;
    int unsigned d;
    best   = 0;
    best_d = color_distance(px, palette_copy[0]);
    for (int unsigned i = 1; i < span && best_d > 0; i++) begin
      d = color_distance(px, palette_copy[i]);
      if (d < best_d) begin
        best   = i;
        best_d = d;
      end
    end
    return WORD_W'(best);
  endfunction

  // advance the packing state by one accepted beat
  task automatic predict_beat();
    logic [PX_W-1:0]   px;
    logic [WORD_W-1:0] value;
    logic [63:0]       wide;
    word_beat_t        w;
    px = {in_ch.alpha, in_ch.blue, in_ch.green, in_ch.red};
    if (in_ch.opcode == OP_LOAD) begin
      if (int'(in_ch.palette_index) < PAL_DEPTH) palette_copy[in_ch.palette_index] = px;
    end else begin
      if (cur_format == FMT_RGBA5551) begin
        value = {16'd0, in_ch.alpha[7], in_ch.blue[7:3], in_ch.green[7:3], in_ch.red[7:3]};
      end else if (cur_format >= FMT_PAL8 && cur_format <= FMT_PAL1) begin
        value = closest_entry(px, search_span(cur_format));
      end else begin
        value = px;
      end
      // bits past bit 31 fall off
      wide       = {32'd0, fill_word} | ({32'd0, value} << (fill_count % 32));
      fill_word  = wide[WORD_W-1:0];
      fill_count = (fill_count % 32) + pixel_bits(cur_format);
      if (fill_count >= 32 || in_ch.row_end) begin
        w.packed_word = fill_word;
        w.row_last    = in_ch.row_end;
        expected_words.push_back(w);
        fill_word  = '0;
        fill_count = 0;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] want,
                                 input logic [WORD_W-1:0] got);
    mismatches++;
    if (mismatches <= 40)
      $display("[%0t] mismatch on %s: expected 0x%08h, got 0x%08h", $time, what, want, got);
  endtask

  // compare one delivered word with the oldest prediction
  task automatic check_word();
    word_beat_t w;
    if (expected_words.size() == 0) begin
      report_mismatch("word beat with nothing pending", '0, out_ch.packed_word);
    end else begin
      w = expected_words.pop_front();
      checked++;
      if (out_ch.packed_word !== w.packed_word)
        report_mismatch("packed_word", w.packed_word, out_ch.packed_word);
      if (out_ch.row_last !== w.row_last)
        report_mismatch("row_last", WORD_W'(w.row_last), WORD_W'(out_ch.row_last));
    end
  endtask

  // sample both channels at the clock edge
  always @(posedge clk) begin
    if (!rst_n) begin
      fill_word  = '0;
      fill_count = 0;
      cur_format = FMT_RGBA8888;
      expected_words.delete();
    end else begin
      if (cfg_we) cur_format = cfg_wdata;
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) predict_beat();
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) check_word();
    end
    fail_count    <= mismatches;
    words_pending <= expected_words.size();
    words_checked <= checked;
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives pixel and palette beats into the packer under several formats and
// idling patterns, with a checker beside the block predicting every word
// ----------------------------------------------------------------------------
module testbench;
  import pfp_pkg::*;

  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 300;
  localparam int LIMIT_CYCLES  = 2000000;
  localparam int N_PHASES      = 12;

  // codes the block treats as rgba8888
  localparam logic [FMT_W-1:0] FMT_SPARE6 = 3'd6;
  localparam logic [FMT_W-1:0] FMT_SPARE7 = 3'd7;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [FMT_W-1:0] cfg_wdata;

  pfp_in_if  in_ch ();
  pfp_out_if out_ch ();

  int               fail_count;
  int               words_pending;
  int               words_checked;
  idle_mode_t       idle_mode = IDLE_NONE;
  int               hold_req_cnt = 0;
  int               cycle_count;
  int               loads_sent;
  int               pixels_sent;
  logic [PX_W-1:0]  palette_colors [PAL_DEPTH];
  logic [FMT_W-1:0] format_now;

  pixel_format_pack u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  pfp_word_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .words_pending (words_pending),
    .words_checked (words_checked)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d words still pending", cycle_count, words_pending);
    $display("FAILURE");
    $finish;
  end

  // word channel ready, with stalls and the long hold-off
  initial begin : word_ready_gen
    int hold_left;
    int hold_seen;
    hold_left    = 0;
    hold_seen    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req_cnt != hold_seen) begin
        hold_seen = hold_req_cnt;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (idle_mode)
          IDLE_RECEIVER: out_ch.ready <= ($urandom_range(99) >= 88);
          IDLE_BOTH:     out_ch.ready <= ($urandom_range(99) >= 15);
          default:       out_ch.ready <= 1'b1;
        endcase
      end
    end
  end

  function automatic logic [FMT_W-1:0] phase_format(input int p);
    case (p)
      0:       return FMT_RGBA8888;
      1:       return FMT_RGBA5551;
      2:       return FMT_PAL1;
      3:       return FMT_PAL2;
      4:       return FMT_PAL4;
      5:       return FMT_PAL8;
      6:       return FMT_SPARE6;
      7:       return FMT_SPARE7;
      8:       return FMT_RGBA5551;
      9:       return FMT_PAL1;
      10:      return FMT_PAL4;
      default: return FMT_PAL2;
    endcase
  endfunction

  // full pal8 searches are slow, so that phase stays short
  function automatic int phase_items(input int p);
    case (p)
      3, 4, 10: return 30;
      5:        return 8;
      6, 7:     return 15;
      11:       return 25;
      default:  return 35;
    endcase
  endfunction

  // offer one beat and wait until it is taken
  task automatic send_beat(input logic op, input logic [CH_W-1:0] idx,
                           input logic [PX_W-1:0] color, input logic last);
    int gap_pct;
    gap_pct = (idle_mode == IDLE_SENDER) ? 88 : (idle_mode == IDLE_BOTH) ? 15 : 0;
    while ($urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.opcode        <= op;
    in_ch.palette_index <= idx;
    in_ch.red           <= color[7:0];
    in_ch.green         <= color[15:8];
    in_ch.blue          <= color[23:16];
    in_ch.alpha         <= color[31:24];
    in_ch.row_end       <= last;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    if (op == OP_LOAD) begin
      loads_sent++;
      palette_colors[idx] = color;
    end else begin
      pixels_sent++;
    end
  endtask

  // stop offering, wait for every word, then let any search finish
  task automatic drain_and_settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_format(input logic [FMT_W-1:0] f);
    drain_and_settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= f;
    @(posedge clk);
    cfg_we     <= 1'b0;
    format_now = f;
  endtask

  // mostly pixels, with exact and near palette hits, some loads and row ends
  task automatic send_random_item();
    logic [PX_W-1:0] color;
    int              span;
    int              pick;
    color = $urandom();
    if ($urandom_range(99) < 12) begin
      send_beat(OP_LOAD, CH_W'($urandom_range(255)), color, 1'($urandom_range(1)));
    end else begin
      span = (format_now == FMT_PAL8) ? 256 : (format_now == FMT_PAL4) ? 16 :
             (format_now == FMT_PAL2) ? 4 : 2;
      pick = $urandom_range(99);
      if (pick < 25) color = palette_colors[$urandom_range(span - 1)];
      else if (pick < 40) color = palette_colors[$urandom_range(span - 1)] ^ PX_W'($urandom_range(3));
      else if (pick < 43) color = '0;
      else if (pick < 46) color = '1;
      send_beat(OP_PIXEL, CH_W'($urandom_range(255)), color, $urandom_range(7) == 0);
    end
  endtask

  // stimulus
  initial begin : stimulus
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = FMT_RGBA8888;
    in_ch.valid         = 1'b0;
    in_ch.opcode        = OP_LOAD;
    in_ch.palette_index = '0;
    in_ch.red           = '0;
    in_ch.green         = '0;
    in_ch.blue          = '0;
    in_ch.alpha         = '0;
    in_ch.row_end       = 1'b0;
    loads_sent          = 0;
    pixels_sent         = 0;
    format_now          = FMT_RGBA8888;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // load every entry first so no search reads an unloaded one
    for (int i = 0; i < PAL_DEPTH; i++) send_beat(OP_LOAD, CH_W'(i), $urandom(), 1'b0);

    // rgba8888 extremes, row end on an empty word
    send_beat(OP_PIXEL, 8'h00, 32'h0000_0000, 1'b0);
    send_beat(OP_PIXEL, 8'hff, 32'hffff_ffff, 1'b1);

    // rgba5551 truncation, two pixels per word, half word at row end
    write_format(FMT_RGBA5551);
    send_beat(OP_PIXEL, 8'h00, 32'hffff_ffff, 1'b0);
    send_beat(OP_PIXEL, 8'h00, 32'h7ff8_0807, 1'b0);
    send_beat(OP_PIXEL, 8'h00, 32'h8007_f808, 1'b1);

    // pal1 with black and white entries, exact hits and a short row
    send_beat(OP_LOAD, 8'd0, 32'h0000_0000, 1'b1);
    send_beat(OP_LOAD, 8'd1, 32'hffff_ffff, 1'b0);
    write_format(FMT_PAL1);
    send_beat(OP_PIXEL, 8'h00, 32'hffff_ffff, 1'b0);
    send_beat(OP_PIXEL, 8'h00, 32'h0101_0101, 1'b0);
    send_beat(OP_PIXEL, 8'h00, 32'hf0f0_f0f0, 1'b1);
    send_beat(OP_PIXEL, 8'h00, 32'h8080_8080, 1'b1);

    // pal2 with duplicate entries, the lower index wins the tie
    send_beat(OP_LOAD, 8'd2, 32'h4050_6070, 1'b0);
    send_beat(OP_LOAD, 8'd3, 32'h4050_6070, 1'b0);
    write_format(FMT_PAL2);
    send_beat(OP_PIXEL, 8'h00, 32'h4050_6070, 1'b0);
    send_beat(OP_PIXEL, 8'h00, 32'h4050_6071, 1'b1);

    // pal4 part word, then a switch to rgba8888 mid-word
    write_format(FMT_PAL4);
    for (int i = 0; i < 3; i++) send_beat(OP_PIXEL, 8'h00, $urandom(), 1'b0);
    write_format(FMT_RGBA8888);
    send_beat(OP_PIXEL, 8'h00, 32'hdead_beef, 1'b0);

    // spare format code packs like rgba8888
    write_format(FMT_SPARE7);
    send_beat(OP_PIXEL, 8'h00, $urandom(), 1'b0);

    // one full pal8 search
    write_format(FMT_PAL8);
    send_beat(OP_PIXEL, 8'h00, $urandom(), 1'b1);

    // random phases over formats and idling patterns
    for (int p = 0; p < N_PHASES; p++) begin
      write_format(phase_format(p));
      idle_mode = idle_mode_t'(p % 4);
      for (int i = 0; i < phase_items(p); i++) send_random_item();
    end

    // receiver holds off while pixels keep coming, so the input stalls
    write_format(FMT_RGBA8888);
    idle_mode = IDLE_NONE;
    hold_req_cnt++;
    for (int i = 0; i < 40; i++) send_random_item();

    drain_and_settle();
    $display("run covered %0d palette loads and %0d pixels over all format codes,",
             loads_sent, pixels_sent);
    $display("idling on both sides, a long word hold-off and %0d checked words",
             words_checked);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
